### rtl/core/rbls_pkg.sv
// Shared types, register-file map and microcode ROM for the rigid body leapfrog step.
`default_nettype none
package rbls_pkg;

    localparam int RF_AW    = 5;
    localparam int RF_DEPTH = 23;
    localparam int PC_W     = 7;
    localparam int DIV_NUM_W = 36;   // magnitude of a dividend before the fraction shift
    localparam int DEN_W     = 33;   // norm or mass

    localparam logic [30:0] MASS_RST = 31'd65536;
    localparam logic [30:0] GRAV_RST = 31'd642908;

    // configuration register indexes
    localparam logic [2:0] CFG_MASS   = 3'd0;
    localparam logic [2:0] CFG_THRUST = 3'd1;
    localparam logic [2:0] CFG_GRAV   = 3'd2;
    localparam logic [2:0] CFG_DRAG   = 3'd3;
    localparam logic [2:0] CFG_SPIN_X = 3'd4;
    localparam logic [2:0] CFG_SPIN_Y = 3'd5;
    localparam logic [2:0] CFG_SPIN_Z = 3'd6;

    // register file map
    localparam logic [RF_AW-1:0] R_PX = 5'd0,  R_PY = 5'd1,  R_PZ = 5'd2;
    localparam logic [RF_AW-1:0] R_VX = 5'd3,  R_VY = 5'd4,  R_VZ = 5'd5;
    localparam logic [RF_AW-1:0] R_AZ = 5'd6;
    localparam logic [RF_AW-1:0] R_QW = 5'd7,  R_QX = 5'd8,  R_QY = 5'd9,  R_QZ = 5'd10;
    localparam logic [RF_AW-1:0] R_DT = 5'd11;
    localparam logic [RF_AW-1:0] R_MASS = 5'd12, R_THR = 5'd13, R_GRAV = 5'd14;
    localparam logic [RF_AW-1:0] R_DRAG = 5'd15;
    localparam logic [RF_AW-1:0] R_SX = 5'd16, R_SY = 5'd17, R_SZ = 5'd18;
    localparam logic [RF_AW-1:0] R_T0 = 5'd19, R_T1 = 5'd20, R_T2 = 5'd21, R_T3 = 5'd22;
    localparam logic [RF_AW-1:0] R_T4 = 5'd19;  // product scratch shares T0 only where T0 is dead

    typedef enum logic [4:0] {
        OP_NOP, OP_MUL, OP_RND, OP_ACCLD, OP_ACCNG, OP_ACCADD, OP_ACCSUB, OP_ST,
        OP_N2CLR, OP_N2ADD, OP_SQRT, OP_JZ, OP_DIVR, OP_DIVF, OP_SETONE, OP_CLR,
        OP_JMP, OP_DONE
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [RF_AW-1:0] dst;
        logic [RF_AW-1:0] ra;
        logic [RF_AW-1:0] rb;
        logic            sh1;   // round shift by one more bit (half step)
        logic [PC_W-1:0] tgt;
    } ctl_t;

    typedef struct packed {
        logic done;       // long operation finished this cycle
        logic norm_zero;
    } stat_t;

    typedef struct packed {
        logic signed [17:0] quat_z;
        logic signed [17:0] quat_y;
        logic signed [17:0] quat_x;
        logic signed [17:0] quat_w;
        logic signed [31:0] vel_z;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } result_t;

    function automatic ctl_t c(op_t op, logic [RF_AW-1:0] dst, logic [RF_AW-1:0] ra,
                               logic [RF_AW-1:0] rb, logic sh1, logic [PC_W-1:0] tgt);
        ctl_t w;
        w.op = op; w.dst = dst; w.ra = ra; w.rb = rb; w.sh1 = sh1; w.tgt = tgt;
        return w;
    endfunction

    function automatic ctl_t u_mul(logic [RF_AW-1:0] a, logic [RF_AW-1:0] b);
        return c(OP_MUL, R_T0, a, b, 1'b0, '0);
    endfunction

    function automatic ctl_t u_rnd(logic [RF_AW-1:0] d, logic s);
        return c(OP_RND, d, R_T0, R_T0, s, '0);
    endfunction

    function automatic ctl_t u_acc(op_t op, logic [RF_AW-1:0] a);
        return c(op, a, a, a, 1'b0, '0);
    endfunction

    function automatic ctl_t u_jmp(op_t op, logic [PC_W-1:0] t);
        return c(op, R_T0, R_T0, R_T0, 1'b0, t);
    endfunction

    // Program: half kick, drift, body rates, attitude update, renormalize,
    // vertical force and division by mass, second half kick.
    function automatic ctl_t ucode(logic [PC_W-1:0] pc);
        ctl_t w;
        case (pc)
            7'd0:   w = u_mul(R_AZ, R_DT);
            7'd1:   w = u_rnd(R_T1, 1'b1);
            7'd2:   w = u_acc(OP_ACCLD, R_VZ);
            7'd3:   w = u_acc(OP_ACCADD, R_T1);
            7'd4:   w = u_acc(OP_ST, R_VZ);
            7'd5:   w = u_mul(R_VX, R_DT);
            7'd6:   w = u_rnd(R_T1, 1'b0);
            7'd7:   w = u_acc(OP_ACCLD, R_PX);
            7'd8:   w = u_acc(OP_ACCADD, R_T1);
            7'd9:   w = u_acc(OP_ST, R_PX);
            7'd10:  w = u_mul(R_VY, R_DT);
            7'd11:  w = u_rnd(R_T1, 1'b0);
            7'd12:  w = u_acc(OP_ACCLD, R_PY);
            7'd13:  w = u_acc(OP_ACCADD, R_T1);
            7'd14:  w = u_acc(OP_ST, R_PY);
            7'd15:  w = u_mul(R_VZ, R_DT);
            7'd16:  w = u_rnd(R_T1, 1'b0);
            7'd17:  w = u_acc(OP_ACCLD, R_PZ);
            7'd18:  w = u_acc(OP_ACCADD, R_T1);
            7'd19:  w = u_acc(OP_ST, R_PZ);
            // rate w: -x*sx - y*sy - z*sz  (scratch T3 is free until rate z)
            7'd20:  w = u_mul(R_QX, R_SX);
            7'd21:  w = u_rnd(R_T3, 1'b0);
            7'd22:  w = u_acc(OP_ACCNG, R_T3);
            7'd23:  w = u_mul(R_QY, R_SY);
            7'd24:  w = u_rnd(R_T3, 1'b0);
            7'd25:  w = u_acc(OP_ACCSUB, R_T3);
            7'd26:  w = u_mul(R_QZ, R_SZ);
            7'd27:  w = u_rnd(R_T3, 1'b0);
            7'd28:  w = u_acc(OP_ACCSUB, R_T3);
            7'd29:  w = u_acc(OP_ST, R_T0);
            // rate x: w*sx + y*sz - z*sy
            7'd30:  w = u_mul(R_QW, R_SX);
            7'd31:  w = u_rnd(R_T3, 1'b0);
            7'd32:  w = u_acc(OP_ACCLD, R_T3);
            7'd33:  w = u_mul(R_QY, R_SZ);
            7'd34:  w = u_rnd(R_T3, 1'b0);
            7'd35:  w = u_acc(OP_ACCADD, R_T3);
            7'd36:  w = u_mul(R_QZ, R_SY);
            7'd37:  w = u_rnd(R_T3, 1'b0);
            7'd38:  w = u_acc(OP_ACCSUB, R_T3);
            7'd39:  w = u_acc(OP_ST, R_T1);
            // rate y: w*sy - x*sz + z*sx
            7'd40:  w = u_mul(R_QW, R_SY);
            7'd41:  w = u_rnd(R_T3, 1'b0);
            7'd42:  w = u_acc(OP_ACCLD, R_T3);
            7'd43:  w = u_mul(R_QX, R_SZ);
            7'd44:  w = u_rnd(R_T3, 1'b0);
            7'd45:  w = u_acc(OP_ACCSUB, R_T3);
            7'd46:  w = u_mul(R_QZ, R_SX);
            7'd47:  w = u_rnd(R_T3, 1'b0);
            7'd48:  w = u_acc(OP_ACCADD, R_T3);
            7'd49:  w = u_acc(OP_ST, R_T2);
            // rate z: w*sz + x*sy - y*sx, scratch in DT-free reg T3 then stored to T3
            7'd50:  w = u_mul(R_QW, R_SZ);
            7'd51:  w = u_rnd(R_T3, 1'b0);
            7'd52:  w = u_acc(OP_ACCLD, R_T3);
            7'd53:  w = u_mul(R_QX, R_SY);
            7'd54:  w = u_rnd(R_T3, 1'b0);
            7'd55:  w = u_acc(OP_ACCADD, R_T3);
            7'd56:  w = u_mul(R_QY, R_SX);
            7'd57:  w = u_rnd(R_T3, 1'b0);
            7'd58:  w = u_acc(OP_ACCSUB, R_T3);
            7'd59:  w = u_acc(OP_ST, R_T3);
            // q[i] += rate[i]*dt/2 ; the rounded increment lands in the rate register
            7'd60:  w = u_mul(R_T0, R_DT);
            7'd61:  w = u_rnd(R_T0, 1'b1);
            7'd62:  w = u_acc(OP_ACCLD, R_QW);
            7'd63:  w = u_acc(OP_ACCADD, R_T0);
            7'd64:  w = u_acc(OP_ST, R_QW);
            7'd65:  w = u_mul(R_T1, R_DT);
            7'd66:  w = u_rnd(R_T1, 1'b1);
            7'd67:  w = u_acc(OP_ACCLD, R_QX);
            7'd68:  w = u_acc(OP_ACCADD, R_T1);
            7'd69:  w = u_acc(OP_ST, R_QX);
            7'd70:  w = u_mul(R_T2, R_DT);
            7'd71:  w = u_rnd(R_T2, 1'b1);
            7'd72:  w = u_acc(OP_ACCLD, R_QY);
            7'd73:  w = u_acc(OP_ACCADD, R_T2);
            7'd74:  w = u_acc(OP_ST, R_QY);
            7'd75:  w = u_mul(R_T3, R_DT);
            7'd76:  w = u_rnd(R_T3, 1'b1);
            7'd77:  w = u_acc(OP_ACCLD, R_QZ);
            7'd78:  w = u_acc(OP_ACCADD, R_T3);
            7'd79:  w = u_acc(OP_ST, R_QZ);
            7'd80:  w = u_jmp(OP_N2CLR, '0);
            7'd81:  w = u_mul(R_QW, R_QW);
            7'd82:  w = u_jmp(OP_N2ADD, '0);
            7'd83:  w = u_mul(R_QX, R_QX);
            7'd84:  w = u_jmp(OP_N2ADD, '0);
            7'd85:  w = u_mul(R_QY, R_QY);
            7'd86:  w = u_jmp(OP_N2ADD, '0);
            7'd87:  w = u_mul(R_QZ, R_QZ);
            7'd88:  w = u_jmp(OP_N2ADD, '0);
            7'd89:  w = u_jmp(OP_SQRT, '0);
            7'd90:  w = u_jmp(OP_JZ, 7'd96);
            7'd91:  w = u_acc(OP_DIVR, R_QW);
            7'd92:  w = u_acc(OP_DIVR, R_QX);
            7'd93:  w = u_acc(OP_DIVR, R_QY);
            7'd94:  w = u_acc(OP_DIVR, R_QZ);
            7'd95:  w = u_jmp(OP_JMP, 7'd100);
            7'd96:  w = u_acc(OP_SETONE, R_QW);
            7'd97:  w = u_acc(OP_CLR, R_QX);
            7'd98:  w = u_acc(OP_CLR, R_QY);
            7'd99:  w = u_acc(OP_CLR, R_QZ);
            // force = thrust - mass*g - drag*vz^2/2
            7'd100: w = u_mul(R_MASS, R_GRAV);
            7'd101: w = u_rnd(R_T0, 1'b0);
            7'd102: w = u_mul(R_VZ, R_VZ);
            7'd103: w = u_rnd(R_T1, 1'b0);
            7'd104: w = u_mul(R_DRAG, R_T1);
            7'd105: w = u_rnd(R_T1, 1'b1);
            7'd106: w = u_acc(OP_ACCLD, R_THR);
            7'd107: w = u_acc(OP_ACCSUB, R_T0);
            7'd108: w = u_acc(OP_ACCSUB, R_T1);
            7'd109: w = u_acc(OP_DIVF, R_AZ);
            7'd110: w = u_mul(R_AZ, R_DT);
            7'd111: w = u_rnd(R_T1, 1'b1);
            7'd112: w = u_acc(OP_ACCLD, R_VZ);
            7'd113: w = u_acc(OP_ACCADD, R_T1);
            7'd114: w = u_acc(OP_ST, R_VZ);
            7'd115: w = u_jmp(OP_DONE, '0);
            default: w = u_jmp(OP_DONE, '0);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

### rtl/core/rbls_div.sv
// Radix-2 restoring divider: rounded (mag << FRAC) / den, clamped and signed to 32 bits.
`default_nettype none
module rbls_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [rbls_pkg::DIV_NUM_W-1:0]  mag,
    input  wire logic                            neg,
    input  wire logic [rbls_pkg::DEN_W-1:0]      den,
    output logic                                 done,
    output logic signed [31:0]                   quo
);
    import rbls_pkg::*;

    localparam int DW  = DIV_NUM_W + FRAC_BITS + 1;
    localparam int CW  = $clog2(DW + 1);
    localparam int RW  = DEN_W + 1;

    logic [DW-1:0]  dvd_reg, dvd_next;
    logic [DW-1:0]  q_reg, q_next;
    logic [RW-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           neg_reg, neg_next;
    logic           zero_reg, zero_next;
    logic [RW-1:0]  rem_sh;
    logic [DW-1:0]  q_clamp;
    logic [DW:0]    q_signed;

    always_comb
    begin
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        done      = 1'b0;
        rem_sh    = {rem_reg[RW-2:0], dvd_reg[DW-1]};
        if (start)
        begin
            dvd_next  = ({{(DW - DIV_NUM_W){1'b0}}, mag} << FRAC_BITS)
                        + {{(DW - DEN_W + 1){1'b0}}, den[DEN_W-1:1]};
            q_next    = '0;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
            neg_next  = neg;
            zero_next = (mag == '0);
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                q_next   = {q_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    // q_next holds the finished quotient in the cycle done is raised
    always_comb
    begin
        if (zero_reg)
            q_clamp = '0;
        else if (q_next > (DW'(1) << 31))
            q_clamp = DW'(1) << 31;
        else
            q_clamp = q_next;
        q_signed = neg_reg ? -{1'b0, q_clamp} : {1'b0, q_clamp};
        if (!neg_reg && q_clamp[31])
            quo = 32'sh7FFF_FFFF;
        else
            quo = q_signed[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

endmodule
`default_nettype wire

### rtl/core/rbls_sqrt.sv
// Digit-by-digit integer square root of a 64-bit value, two radicand bits per cycle.
`default_nettype none
module rbls_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] rad,
    output logic             done,
    output logic [31:0]      root
);
    import rbls_pkg::*;

    logic [63:0] n_reg, n_next;
    logic [31:0] root_reg, root_next;
    logic [35:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [35:0] rem_sh;
    logic [35:0] trial;

    always_comb
    begin
        n_next    = n_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        rem_sh    = {rem_reg[33:0], n_reg[63:62]};
        trial     = {2'b00, root_reg, 2'b01};
        if (start)
        begin
            n_next    = rad;
            root_next = '0;
            rem_next  = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next = {n_reg[61:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign root = root_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

endmodule
`default_nettype wire

### rtl/core/rbls_seq.sv
// Microcode sequencer: step counter, ROM fetch, waits on long operations and on a free output, jumps.
`default_nettype none
module rbls_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic           out_free,
    input  wire rbls_pkg::stat_t stat,
    output rbls_pkg::ctl_t      ctl,
    output logic                busy,
    output logic                finish
);
    import rbls_pkg::*;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            run_reg, run_next;
    ctl_t            word;

    assign word = ucode(pc_reg);
    assign busy = run_reg;

    always_comb
    begin
        ctl       = word;
        pc_next   = pc_reg;
        run_next  = run_reg;
        finish    = 1'b0;
        if (!run_reg)
        begin
            ctl.op = OP_NOP;
            if (start)
            begin
                run_next = 1'b1;
                pc_next  = '0;
            end
        end
        else
        begin
            case (word.op)
                OP_SQRT, OP_DIVR, OP_DIVF:
                    if (stat.done)
                        pc_next = pc_reg + 1'b1;
                OP_JZ:
                    pc_next = stat.norm_zero ? word.tgt : pc_reg + 1'b1;
                OP_JMP:
                    pc_next = word.tgt;
                OP_DONE:
                    if (out_free)
                    begin
                        finish   = 1'b1;
                        run_next = 1'b0;
                    end
                default:
                    pc_next = pc_reg + 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= '0;
            run_reg <= 1'b0;
        end
        else
        begin
            pc_reg  <= pc_next;
            run_reg <= run_next;
        end
    end

endmodule
`default_nettype wire

### rtl/core/rbls_dp.sv
// Datapath: register file, shared multiplier, rounding, accumulator, norm, sqrt and divider.
`default_nettype none
module rbls_dp #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rbls_pkg::ctl_t  ctl,
    input  wire logic            load_dt,
    input  wire logic [16:0]     time_step,
    input  wire logic            cfg_we,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [31:0]     cfg_data,
    output rbls_pkg::stat_t      stat,
    output rbls_pkg::result_t    res
);
    import rbls_pkg::*;

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    logic signed [31:0] rf_reg [RF_DEPTH];
    logic signed [63:0] prod_reg;
    logic signed [35:0] acc_reg, acc_next;
    logic [64:0]        n2_reg, n2_next;
    logic [32:0]        norm_reg;
    logic               launch_reg, launch_next;

    logic signed [31:0] opa, opb;
    logic [63:0]        pmag, prnd, half;
    logic [6:0]         sh;
    logic signed [31:0] rnd_val, acc_sat;
    logic               is_long, launch;
    logic [DIV_NUM_W-1:0] dmag;
    logic signed [DIV_NUM_W-1:0] dnum;
    logic [DEN_W-1:0]   dden;
    logic               div_done, sqrt_done;
    logic signed [31:0] div_q;
    logic [31:0]        sq_root;

    assign opa = rf_reg[ctl.ra];
    assign opb = rf_reg[ctl.rb];

    // round to nearest, ties away from zero, then saturate
    always_comb
    begin
        sh   = 7'(FRAC_BITS) + {6'd0, ctl.sh1};
        half = 64'd1 << (sh - 7'd1);
        pmag = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
        prnd = (pmag + half) >> sh;
        if (!prod_reg[63])
            rnd_val = (prnd > 64'h7FFF_FFFF) ? S32_MAX : 32'(prnd);
        else
            rnd_val = (prnd > 64'h8000_0000) ? S32_MIN : 32'(-prnd);
        if (acc_reg > 36'sh0_7FFF_FFFF)
            acc_sat = S32_MAX;
        else if (acc_reg < -36'sh0_8000_0000)
            acc_sat = S32_MIN;
        else
            acc_sat = acc_reg[31:0];
    end

    always_comb
    begin
        is_long = (ctl.op == OP_SQRT) || (ctl.op == OP_DIVR) || (ctl.op == OP_DIVF);
        launch  = is_long && !launch_reg;
        launch_next = launch_reg;
        if (launch)
            launch_next = 1'b1;
        else if (div_done || sqrt_done)
            launch_next = 1'b0;
        dnum = (ctl.op == OP_DIVF) ? acc_reg : DIV_NUM_W'(opa);
        dmag = dnum[DIV_NUM_W-1] ? DIV_NUM_W'(-dnum) : DIV_NUM_W'(dnum);
        dden = (ctl.op == OP_DIVF) ? {1'b0, rf_reg[R_MASS]} : norm_reg;
    end

    always_comb
    begin
        acc_next = acc_reg;
        n2_next  = n2_reg;
        case (ctl.op)
            OP_ACCLD:  acc_next = 36'(opa);
            OP_ACCNG:  acc_next = -36'(opa);
            OP_ACCADD: acc_next = acc_reg + 36'(opa);
            OP_ACCSUB: acc_next = acc_reg - 36'(opa);
            OP_N2CLR:  n2_next  = '0;
            OP_N2ADD:  n2_next  = n2_reg + {1'b0, prod_reg};
            default:   acc_next = acc_reg;
        endcase
    end

    rbls_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (launch && (ctl.op != OP_SQRT)),
        .mag   (dmag),
        .neg   (dnum[DIV_NUM_W-1]),
        .den   (dden),
        .done  (div_done),
        .quo   (div_q)
    );

    rbls_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (launch && (ctl.op == OP_SQRT)),
        .rad   (n2_reg[64] ? 64'hFFFF_FFFF_FFFF_FFFF : n2_reg[63:0]),
        .done  (sqrt_done),
        .root  (sq_root)
    );

    assign stat.done      = div_done || sqrt_done;
    assign stat.norm_zero = (norm_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RF_DEPTH; i++)
                rf_reg[i] <= '0;
            rf_reg[R_QW]   <= ONE;
            rf_reg[R_MASS] <= {1'b0, MASS_RST};
            rf_reg[R_GRAV] <= {1'b0, GRAV_RST};
            launch_reg     <= 1'b0;
        end
        else
        begin
            launch_reg <= launch_next;
            if (load_dt)
                rf_reg[R_DT] <= {15'd0, time_step};
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MASS:   rf_reg[R_MASS] <= {1'b0, cfg_data[30:0]};
                    CFG_THRUST: rf_reg[R_THR]  <= {1'b0, cfg_data[30:0]};
                    CFG_GRAV:   rf_reg[R_GRAV] <= {1'b0, cfg_data[30:0]};
                    CFG_DRAG:   rf_reg[R_DRAG] <= {1'b0, cfg_data[30:0]};
                    CFG_SPIN_X: rf_reg[R_SX]   <= cfg_data;
                    CFG_SPIN_Y: rf_reg[R_SY]   <= cfg_data;
                    CFG_SPIN_Z: rf_reg[R_SZ]   <= cfg_data;
                    default:    ;
                endcase
            end
            case (ctl.op)
                OP_RND:    rf_reg[ctl.dst] <= rnd_val;
                OP_ST:     rf_reg[ctl.dst] <= acc_sat;
                OP_SETONE: rf_reg[ctl.dst] <= ONE;
                OP_CLR:    rf_reg[ctl.dst] <= '0;
                OP_DIVR, OP_DIVF:
                    if (div_done)
                        rf_reg[ctl.dst] <= div_q;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_MUL)
            prod_reg <= opa * opb;
        acc_reg <= acc_next;
        n2_reg  <= n2_next;
        if (sqrt_done)
            norm_reg <= {1'b0, sq_root};
    end

    always_comb
    begin
        res.pos_x  = rf_reg[R_PX];
        res.pos_y  = rf_reg[R_PY];
        res.pos_z  = rf_reg[R_PZ];
        res.vel_x  = rf_reg[R_VX];
        res.vel_y  = rf_reg[R_VY];
        res.vel_z  = rf_reg[R_VZ];
        res.quat_w = rf_reg[R_QW][17:0];
        res.quat_x = rf_reg[R_QX][17:0];
        res.quat_y = rf_reg[R_QY][17:0];
        res.quat_z = rf_reg[R_QZ][17:0];
    end

endmodule
`default_nettype wire

### rtl/core/rigid_body_leapfrog_step.sv
// Top level: stream ports, configuration port, output register, sequencer and datapath.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata: time_step
//  m_axis   | out       | tdata: pos_x..z, vel_x..z, quat_w..z
//  cfg      | in        | cfg_index, cfg_data
//
// A step runs the microcode program from the accepting edge to output valid: plain steps, one
// square root and five divides; a zero norm skips the four attitude divides.
// Reset restores the identity attitude, zero motion state and the default registers.
// A finished result waits in the output register; the next step may run meanwhile and
// holds at its last step only while that register is still full.
`default_nettype none
module rigid_body_leapfrog_step #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [23:0]  s_axis_tdata,   // [16:0] time_step
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [263:0]      m_axis_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (32 each),
                                              // quat_w, quat_x, quat_y, quat_z (18 each)
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    import rbls_pkg::*;

    ctl_t    ctl;
    stat_t   stat;
    result_t res;
    logic    busy, finish, in_acc, out_free;
    logic    out_valid_reg, out_valid_next;
    logic [263:0] out_data_reg;

    assign s_axis_tready = !busy;
    assign cfg_ready     = !busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    rbls_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_acc),
        .out_free (out_free),
        .stat     (stat),
        .ctl      (ctl),
        .busy     (busy),
        .finish   (finish)
    );

    rbls_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .load_dt   (in_acc),
        .time_step (s_axis_tdata[16:0]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
            out_data_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> busy)
        else $error("accepted request did not start the program");
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> m_axis_tvalid)
        else $error("finished step did not raise output valid");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten before it was taken");
    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> !busy)
        else $error("sequencer kept running after finish");
`endif

endmodule
`default_nettype wire

### bench/rigid_body_leapfrog_step_tb.sv
// Testbench for the rigid body leapfrog step: predicts each step in fixed point and checks every result.
`default_nettype none
module rigid_body_leapfrog_step_tb;
    import rbls_pkg::*;

    localparam int FB        = 16;
    localparam int STALL_MAX = 20000;   // cycles with no handshake before giving up
    localparam int DRAIN     = 600;
    localparam int HOLD_LEN  = 1500;

    typedef longint fields_t [10];

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [263:0] m_axis_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    rigid_body_leapfrog_step dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // body model
    logic [30:0]        mass_r, thrust_r, grav_r, drag_r;
    logic signed [31:0] spin [3];
    logic signed [31:0] pos [3], vel [3], accel [3], quat [4];

    int       pending_dt [$];
    result_t  expected_states [$];
    int       errors = 0;
    int       send_idle = 0, recv_idle = 0;
    bit       hold_req = 1'b0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       quiet_cycles = 0;

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // rounded shift, ties away from zero
    function automatic longint round_shift(longint p, int sh);
        longint unsigned mag;
        mag = (p < 0) ? -p : p;
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return (p < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic signed [31:0] fx_mul(longint a, longint b, int sh);
        return sat32(round_shift(a * b, sh));
    endfunction

    function automatic logic signed [31:0] fx_div(longint num, longint unsigned den);
        longint unsigned mag, q;
        mag = (num < 0) ? -num : num;
        q = ((mag << FB) + den / 2) / den;
        if (q > 64'd2147483648) q = 64'd2147483648;
        return sat32((num < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic reset_body();
        mass_r = MASS_RST; thrust_r = '0; grav_r = GRAV_RST; drag_r = '0;
        for (int i = 0; i < 3; i++)
        begin
            spin[i] = '0; pos[i] = '0; vel[i] = '0; accel[i] = '0;
        end
        quat[0] = 32'sd1 << FB; quat[1] = '0; quat[2] = '0; quat[3] = '0;
    endtask

    task automatic apply_reg(logic [2:0] idx, logic [31:0] d);
        case (idx)
            CFG_MASS:   mass_r = d[30:0];
            CFG_THRUST: thrust_r = d[30:0];
            CFG_GRAV:   grav_r = d[30:0];
            CFG_DRAG:   drag_r = d[30:0];
            CFG_SPIN_X: spin[0] = d;
            CFG_SPIN_Y: spin[1] = d;
            CFG_SPIN_Z: spin[2] = d;
            default: ;
        endcase
    endtask

    task automatic half_kick(longint dt);
        for (int i = 0; i < 3; i++)
            vel[i] = sat32(longint'(vel[i]) + fx_mul(accel[i], dt, FB + 1));
    endtask

    task automatic advance_body(longint dt, output result_t r);
        longint              rate [4];
        logic signed [31:0]  w, x, y, z, v2, drag, weight;
        longint unsigned     n2, sq, nrm;
        longint              net_force;
        half_kick(dt);
        for (int i = 0; i < 3; i++)
            pos[i] = sat32(longint'(pos[i]) + fx_mul(vel[i], dt, FB));
        w = quat[0]; x = quat[1]; y = quat[2]; z = quat[3];
        rate[0] = -longint'(fx_mul(x, spin[0], FB)) - fx_mul(y, spin[1], FB)
                  - fx_mul(z, spin[2], FB);
        rate[1] = longint'(fx_mul(w, spin[0], FB)) + fx_mul(y, spin[2], FB)
                  - fx_mul(z, spin[1], FB);
        rate[2] = longint'(fx_mul(w, spin[1], FB)) - fx_mul(x, spin[2], FB)
                  + fx_mul(z, spin[0], FB);
        rate[3] = longint'(fx_mul(w, spin[2], FB)) + fx_mul(x, spin[1], FB)
                  - fx_mul(y, spin[0], FB);
        n2 = 0;
        for (int i = 0; i < 4; i++)
        begin
            quat[i] = sat32(longint'(quat[i]) + fx_mul(sat32(rate[i]), dt, FB + 1));
            sq = longint'(quat[i]) * longint'(quat[i]);
            n2 = (n2 > ~64'd0 - sq) ? ~64'd0 : n2 + sq;
        end
        nrm = int_sqrt(n2);
        if (nrm == 0)
        begin
            quat[0] = 32'sd1 << FB; quat[1] = '0; quat[2] = '0; quat[3] = '0;
        end
        else
            for (int i = 0; i < 4; i++)
                quat[i] = fx_div(quat[i], nrm);
        weight = fx_mul(longint'(mass_r), longint'(grav_r), FB);
        v2 = fx_mul(vel[2], vel[2], FB);
        drag = fx_mul(longint'(drag_r), v2, FB + 1);
        net_force = longint'(thrust_r) - weight - drag;
        accel[0] = '0;
        accel[1] = '0;
        if (mass_r == 0)
            accel[2] = (net_force > 0) ? 32'sh7fffffff :
                       ((net_force < 0) ? 32'sh80000000 : '0);
        else
            accel[2] = fx_div(net_force, mass_r);
        half_kick(dt);
        r.pos_x = pos[0]; r.pos_y = pos[1]; r.pos_z = pos[2];
        r.vel_x = vel[0]; r.vel_y = vel[1]; r.vel_z = vel[2];
        r.quat_w = quat[0][17:0]; r.quat_x = quat[1][17:0];
        r.quat_y = quat[2][17:0]; r.quat_z = quat[3][17:0];
    endtask

    function automatic fields_t fields_of(result_t r);
        fields_t f;
        f[0] = r.pos_x; f[1] = r.pos_y; f[2] = r.pos_z;
        f[3] = r.vel_x; f[4] = r.vel_y; f[5] = r.vel_z;
        f[6] = r.quat_w; f[7] = r.quat_x; f[8] = r.quat_y; f[9] = r.quat_z;
        return f;
    endfunction

    // sender: a step request is taken from the pending list
    always @(posedge clk)
    begin
        result_t r;
        if (s_axis_tvalid && s_axis_tready)
        begin
            advance_body(longint'(s_axis_tdata[16:0]), r);
            expected_states.push_back(r);
            void'(pending_dt.pop_front());
        end
        if (!s_axis_tvalid || s_axis_tready)
        begin
            if (rst_n && pending_dt.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, pending_dt[0][16:0]};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: checks results and stalls at random
    always @(posedge clk)
    begin
        result_t act, exp_r;
        fields_t fa, fe;
        string   names [10];
        names = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                  "quat_w", "quat_x", "quat_y", "quat_z"};
        if (m_axis_tvalid && m_axis_tready)
        begin
            act = m_axis_tdata;
            if (expected_states.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
            end
            else
            begin
                exp_r = expected_states.pop_front();
                fa = fields_of(act);
                fe = fields_of(exp_r);
                for (int i = 0; i < 10; i++)
                    if (fa[i] != fe[i])
                    begin
                        errors++;
                        $display("%0t: %s expected %0d actual %0d", $time, names[i],
                                 fe[i], fa[i]);
                    end
            end
        end
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= rst_n && ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_MAX)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, d);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_dt.size() != 0 || s_axis_tvalid || expected_states.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_unsigned();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return {1'($urandom_range(1)), 31'd1};
            3: return $urandom;
            default: return {1'($urandom_range(1)), 7'd0, 24'($urandom_range(0, 24'hff_ffff))};
        endcase
    endfunction

    function automatic logic [31:0] pick_spin();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
        endcase
    endfunction

    function automatic int pick_step();
        case ($urandom_range(9))
            0: return $urandom_range(0, 131071);
            1: return $urandom_range(0, 1) ? 131071 : 0;
            2: return $urandom_range(0, 65536);
            default: return $urandom_range(0, 8192);
        endcase
    endfunction

    initial
    begin
        int directed [$];
        reset_body();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // defaults: free fall with no spin, step extremes
        directed = '{0, 1, 65536, 131071, 65535, 32768, 2, 1000, 43690, 87381};
        foreach (directed[i]) pending_dt.push_back(directed[i]);
        wait_idle();

        // every register at an extreme: spin y at its bottom, the others at their top
        write_reg(CFG_MASS, 32'hffff_ffff);
        write_reg(CFG_THRUST, 32'h7fff_ffff);
        write_reg(CFG_GRAV, 32'h7fff_ffff);
        write_reg(CFG_DRAG, 32'h7fff_ffff);
        write_reg(CFG_SPIN_X, 32'h7fff_ffff);
        write_reg(CFG_SPIN_Y, 32'h8000_0000);
        write_reg(CFG_SPIN_Z, 32'h7fff_ffff);
        write_reg(3'd7, 32'hffff_ffff);
        directed = '{65536, 131071, 1, 0, 4096};
        foreach (directed[i]) pending_dt.push_back(directed[i]);
        wait_idle();

        // zero mass with and without net force
        write_reg(CFG_MASS, 32'h8000_0000);
        write_reg(CFG_THRUST, 32'd0);
        write_reg(CFG_GRAV, 32'd0);
        write_reg(CFG_DRAG, 32'd0);
        write_reg(CFG_SPIN_X, 32'h0001_0000);
        write_reg(CFG_SPIN_Y, 32'hffff_0000);
        write_reg(CFG_SPIN_Z, 32'd0);
        pending_dt.push_back(65536);
        pending_dt.push_back(131071);
        wait_idle();
        write_reg(CFG_THRUST, 32'h0010_0000);
        pending_dt.push_back(65536);
        pending_dt.push_back(1);
        wait_idle();

        for (int ph = 0; ph < 9; ph++)
        begin
            send_idle = (ph < 3) ? 23 : (ph < 6) ? 79 : 0;
            recv_idle = (ph < 3) ? 79 : (ph < 6) ? 23 : 0;
            if (ph == 0)
            begin
                // typical flight: one-ish mass, thrust near weight
                write_reg(CFG_MASS, 32'h0001_0000);
                write_reg(CFG_GRAV, {1'b0, GRAV_RST});
                write_reg(CFG_THRUST, 32'd642908 + 32'($urandom_range(0, 131072)));
                write_reg(CFG_DRAG, 32'h0000_4000);
            end
            else
                for (int k = 0; k < 7; k++)
                    write_reg(3'(k), (k < 4) ? pick_unsigned() : pick_spin());
            if (ph == 7)
                write_reg(3'd7, $urandom);
            for (int n = 0; n < 110; n++)
                pending_dt.push_back(pick_step());
            if (ph == 6)
                hold_req = 1'b1;
            wait_idle();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
